/* hdl/hflc_pkg.sv */
package hflc_pkg;

   localparam int PAYLOAD_BYTES_DEF = 128;
   localparam int PATH_BYTES_DEF    = 64;

   localparam int BYTE_W    = 8;
   localparam int METHOD_W  = 3;
   localparam int STATUS_W  = 10;
   localparam int PLEN_W    = 7;
   localparam int N_METHODS = 6;
   localparam int PREFIX_MAX = 7;

   // result FIFO depth, power of two, at least two
   localparam int RSP_FIFO_DEPTH = 4;

   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_QMARK = 8'h3F;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

   localparam int RESP_VER_LEN   = 7;
   localparam int RESP_SP_OFS    = 8;
   localparam int RESP_DIG_FIRST = 9;
   localparam int RESP_DIG_LAST  = 11;
   localparam int RESP_MIN_BYTES = 12;

   localparam logic [METHOD_W-1:0] METHOD_NONE = 3'd0;

   localparam logic KIND_PATH    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [BYTE_W-1:0] PREFIX_TEXT [N_METHODS][PREFIX_MAX] = '{
      '{"G", "E", "T", " ", 8'h00, 8'h00, 8'h00},
      '{"P", "O", "S", "T", " ", 8'h00, 8'h00},
      '{"P", "U", "T", " ", 8'h00, 8'h00, 8'h00},
      '{"D", "E", "L", "E", "T", "E", " "},
      '{"P", "A", "T", "C", "H", " ", 8'h00},
      '{"H", "E", "A", "D", " ", 8'h00, 8'h00}
   };

   localparam logic [2:0] PREFIX_LEN [N_METHODS] = '{3'd4, 3'd5, 3'd4, 3'd7, 3'd6, 3'd5};

   localparam logic [BYTE_W-1:0] RESP_TEXT [RESP_VER_LEN] = '{
      "H", "T", "T", "P", "/", "1", "."
   };

   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic              last_byte;
   } req_type;

   typedef struct packed {
      logic                record_kind;
      logic [BYTE_W-1:0]   path_char;
      logic [METHOD_W-1:0] method_code;
      logic [STATUS_W-1:0] resp_status;
      logic [PLEN_W-1:0]   path_length;
      logic                end_of_run;
   } rsp_type;

   // results of one byte, in delivery order; count is 0, 1 or 2
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } core_out_type;

endpackage

/* hdl/hflc_channels.sv */
interface hflc_req_if;
   import hflc_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] payload_byte;
   logic              last_byte;

   modport source (output valid, output payload_byte, output last_byte, input ready);
   modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface hflc_rsp_if;
   import hflc_pkg::*;

   logic                valid;
   logic                ready;
   logic                record_kind;
   logic [BYTE_W-1:0]   path_char;
   logic [METHOD_W-1:0] method_code;
   logic [STATUS_W-1:0] resp_status;
   logic [PLEN_W-1:0]   path_length;
   logic                end_of_run;

   modport source (output valid, output record_kind, output path_char, output method_code,
                   output resp_status, output path_length, output end_of_run, input ready);
   modport sink   (input valid, input record_kind, input path_char, input method_code,
                   input resp_status, input path_length, input end_of_run, output ready);
endinterface

/* hdl/hflc_parse_core.sv */
module hflc_parse_core #(
   parameter int PAYLOAD_BYTES = hflc_pkg::PAYLOAD_BYTES_DEF,
   parameter int PATH_BYTES    = hflc_pkg::PATH_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  hflc_pkg::req_type     item,
   output hflc_pkg::core_out_type result
);
   import hflc_pkg::*;

   localparam int OFS_W = $clog2(PAYLOAD_BYTES + 1);
   localparam int CNT_W = $clog2(PATH_BYTES + 1);

   logic [OFS_W-1:0]     offset_ff, offset_in;
   logic [N_METHODS-1:0] cand_ff, cand_in;
   logic                 resp_ff, resp_in;
   logic [METHOD_W-1:0]  method_ff, method_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic                 pact_ff, pact_in;
   logic [CNT_W-1:0]     pcnt_ff, pcnt_in;

   always_comb begin
      logic                in_window;
      logic                path_hit;
      logic [CNT_W-1:0]    plen_next;
      logic [BYTE_W-1:0]   b;
      logic [3:0]          digit;
      logic [12:0]         mul10;
      logic [STATUS_W-1:0] status_sum;
      rsp_type             path_rsp;
      rsp_type             sum_rsp;

      b         = item.payload_byte;
      offset_in = offset_ff;
      cand_in   = cand_ff;
      resp_in   = resp_ff;
      method_in = method_ff;
      status_in = status_ff;
      pact_in   = pact_ff;
      pcnt_in   = pcnt_ff;
      path_hit  = 1'b0;
      plen_next = pcnt_ff;
      digit     = 4'(b - CH_ZERO);
      // times ten as 8x + 2x; only the low bits are kept
      mul10     = {status_ff, 3'b000} + {2'b00, status_ff, 1'b0};
      in_window = offset_ff < OFS_W'(PAYLOAD_BYTES);

      if (in_window) begin
         // path bytes follow a matched prefix; the flag comes from earlier bytes
         if (pact_ff) begin
            if (b == CH_SPACE || b == CH_QMARK || b == CH_CR) begin
               pact_in = 1'b0;
            end else if (pcnt_ff < CNT_W'(PATH_BYTES)) begin
               plen_next = pcnt_ff + 1'b1;
               pcnt_in   = plen_next;
               path_hit  = 1'b1;
               if (plen_next == CNT_W'(PATH_BYTES)) begin
                  pact_in = 1'b0;
               end
            end else begin
               pact_in = 1'b0;
            end
         end

         for (int m = 0; m < N_METHODS; m++) begin
            if (offset_ff < OFS_W'(PREFIX_LEN[m])) begin
               if (b != PREFIX_TEXT[m][offset_ff[2:0]]) begin
                  cand_in[m] = 1'b0;
               end
               if (offset_ff == OFS_W'(PREFIX_LEN[m]) - 1'b1 && cand_in[m]
                   && method_in == METHOD_NONE) begin
                  method_in = METHOD_W'(m + 1);
                  pact_in   = 1'b1;
                  pcnt_in   = '0;
               end
            end
         end

         if (resp_ff) begin
            if (offset_ff < OFS_W'(RESP_VER_LEN)) begin
               if (b != RESP_TEXT[offset_ff[2:0]]) begin
                  resp_in = 1'b0;
               end
            end else if (offset_ff == OFS_W'(RESP_SP_OFS)) begin
               if (b != CH_SPACE) begin
                  resp_in = 1'b0;
               end
            end else if (offset_ff >= OFS_W'(RESP_DIG_FIRST)
                         && offset_ff <= OFS_W'(RESP_DIG_LAST)) begin
               if (b >= CH_ZERO && b <= CH_NINE) begin
                  status_in = STATUS_W'(mul10 + {9'd0, digit});
               end else begin
                  resp_in = 1'b0;
               end
            end
         end

         offset_in = offset_ff + 1'b1;
      end

      status_sum = (method_in == METHOD_NONE && resp_in
                    && offset_in >= OFS_W'(RESP_MIN_BYTES)) ? status_in : '0;

      path_rsp.record_kind = KIND_PATH;
      path_rsp.path_char   = b;
      path_rsp.method_code = method_ff;
      path_rsp.resp_status = '0;
      path_rsp.path_length = PLEN_W'(plen_next);
      path_rsp.end_of_run  = ~item.last_byte;

      sum_rsp.record_kind = KIND_SUMMARY;
      sum_rsp.path_char   = '0;
      sum_rsp.method_code = method_in;
      sum_rsp.resp_status = status_sum;
      sum_rsp.path_length = PLEN_W'(pcnt_in);
      sum_rsp.end_of_run  = 1'b1;

      result.first  = path_hit ? path_rsp : sum_rsp;
      result.second = sum_rsp;
      if (!fire) begin
         result.count = 2'd0;
      end else begin
         result.count = 2'(path_hit) + 2'(item.last_byte);
      end

      // close the payload: return to the idle parse state
      if (item.last_byte) begin
         offset_in = '0;
         cand_in   = '1;
         resp_in   = 1'b1;
         method_in = METHOD_NONE;
         status_in = '0;
         pact_in   = 1'b0;
         pcnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         cand_ff   <= '1;
         resp_ff   <= 1'b1;
         method_ff <= METHOD_NONE;
         status_ff <= '0;
         pact_ff   <= 1'b0;
         pcnt_ff   <= '0;
      end else if (fire) begin
         offset_ff <= offset_in;
         cand_ff   <= cand_in;
         resp_ff   <= resp_in;
         method_ff <= method_in;
         status_ff <= status_in;
         pact_ff   <= pact_in;
         pcnt_ff   <= pcnt_in;
      end
   end

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      result.count == 2'd2 |-> result.first.record_kind == KIND_PATH
                               && result.second.record_kind == KIND_SUMMARY)
      else $error("two results must be path then summary");

   a_path_bound: assert property (@(posedge clock) disable iff (reset)
      pcnt_ff <= CNT_W'(PATH_BYTES))
      else $error("path count beyond limit");

   a_path_needs_method: assert property (@(posedge clock) disable iff (reset)
      pact_ff |-> method_ff != METHOD_NONE)
      else $error("path active without a matched method");

endmodule

/* hdl/hflc_rsp_fifo.sv */
module hflc_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  hflc_pkg::core_out_type push,
   input  logic                   pop,
   output hflc_pkg::rsp_type      head,
   output logic                   nonempty,
   output logic                   room_two
);
   import hflc_pkg::*;

   localparam int PTR_W = $clog2(RSP_FIFO_DEPTH);
   localparam int CNT_W = $clog2(RSP_FIFO_DEPTH + 1);

   rsp_type          mem_ff [RSP_FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_pop;
   logic [CNT_W-1:0] cnt_after_pop;

   assign nonempty      = cnt_ff != '0;
   assign do_pop        = pop && nonempty;
   assign cnt_after_pop = cnt_ff - CNT_W'(do_pop);
   assign room_two      = cnt_after_pop <= CNT_W'(RSP_FIFO_DEPTH - 2);
   assign head          = mem_ff[rd_ff];

   assign wr_in  = wr_ff + PTR_W'(push.count);
   assign rd_in  = rd_ff + PTR_W'(do_pop);
   assign cnt_in = cnt_after_pop + CNT_W'(push.count);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ff + 1'b1] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> CNT_W'(push.count) <= CNT_W'(RSP_FIFO_DEPTH) - cnt_after_pop)
      else $error("result FIFO overflow");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      PTR_W'(wr_ff - rd_ff) == PTR_W'(cnt_ff))
      else $error("FIFO pointers and count disagree");

endmodule

/* hdl/http_first_line_classifier.sv */
// Channel   Direction  Transaction payload
// --------  ---------  ------------------------------------------------------------
// req_chan  in         payload_byte[7:0], last_byte
// rsp_chan  out        record_kind, path_char[7:0], method_code[2:0], resp_status[9:0],
//                      path_length[6:0], end_of_run
//
// One payload byte per cycle while the FIFO has room for two more results. A byte is
// held in the input register, parsed in a single pass and lands in a four-entry
// result FIFO; its first result is offered the cycle after that. A last byte that
// is also a path byte yields two results, so the result port, one transaction per
// cycle, then sets the pace. Synchronous reset clears parse state and FIFO pointers.
// Stalls on rsp_chan back up into req_chan.ready only once the FIFO cannot take two
// more results.
module http_first_line_classifier #(
   parameter int PAYLOAD_BYTES = hflc_pkg::PAYLOAD_BYTES_DEF,
   parameter int PATH_BYTES    = hflc_pkg::PATH_BYTES_DEF
) (
   input logic        clock,
   input logic        reset,
   hflc_req_if.sink   req_chan,
   hflc_rsp_if.source rsp_chan
);
   import hflc_pkg::*;

   // input register stage
   logic         in_valid_ff, in_valid_in;
   req_type      in_item_ff;
   logic         req_take;
   logic         consume;

   core_out_type core_res;
   rsp_type      head;
   logic         nonempty;
   logic         room_two;

   // parse the held byte only when the FIFO can absorb its worst case of two results
   assign consume  = in_valid_ff && room_two;
   assign req_chan.ready = !in_valid_ff || consume;
   assign req_take = req_chan.valid && req_chan.ready;
   assign in_valid_in = req_take || (in_valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload register: load on every accepted transaction
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.payload_byte <= req_chan.payload_byte;
         in_item_ff.last_byte    <= req_chan.last_byte;
      end
   end

   hflc_parse_core #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES),
      .PATH_BYTES    (PATH_BYTES)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (consume),
      .item   (in_item_ff),
      .result (core_res)
   );

   hflc_rsp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (core_res),
      .pop      (rsp_chan.ready),
      .head     (head),
      .nonempty (nonempty),
      .room_two (room_two)
   );

   // drive the result channel straight from the FIFO entry at the read pointer
   assign rsp_chan.valid       = nonempty;
   assign rsp_chan.record_kind = head.record_kind;
   assign rsp_chan.path_char   = head.path_char;
   assign rsp_chan.method_code = head.method_code;
   assign rsp_chan.resp_status = head.resp_status;
   assign rsp_chan.path_length = head.path_length;
   assign rsp_chan.end_of_run  = head.end_of_run;

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !room_two |=> in_valid_ff)
      else $error("held byte dropped while FIFO was full");

endmodule
